@@ sv/sse_pkg.sv @@
// Package for the searchable stack engine: command and status codes and the
// input and result beat structs. No dependencies.
`timescale 1ns / 1ps

package sse_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN
  } state_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    cmd_e            cmd;
    logic [KeyW-1:0] key;
  } item_t;

  typedef struct packed {
    logic [KeyW-1:0]   popped_key;
    logic              found;
    logic [CountW-1:0] position;
    logic [CountW-1:0] depth_now;
    status_e           status;
  } result_t;

endpackage

@@ sv/searchable_stack_engine.sv @@
// Searchable stack engine top level: LIFO of keys in one synchronous memory
// with push, pop, search and delete-all-matching. Depends on sse_pkg.
`timescale 1ns / 1ps

// A beat is taken on a rising edge where start is high and busy is low; each
// beat produces exactly one result beat, shown on res_o for one cycle while
// res_valid_o is high. The receiver cannot stall: it must take every result
// beat in the cycle it appears. A push, and a pop, search or delete on an
// empty store, register the result at the accept edge; a pop otherwise first
// reads the top entry. Search and delete walk the entry memory, one read per
// cycle through its single registered read port; search ends early at the first
// match, topmost first; delete compacts in place through the write port,
// trailing the read pointer. busy is high until the result is registered, so
// the next beat may be accepted in the cycle its predecessor's result is shown.
// Entry memory holds no reset value; only entries below the fill count are
// ever used. depth_now and position are reported modulo 32.
module searchable_stack_engine #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned KEY_W       = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sse_pkg::item_t   item_i,
  output logic             res_valid_o,
  output sse_pkg::result_t res_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // entry memory: one write and one registered read per cycle
  logic [KEY_W-1:0] mem [STACK_DEPTH];
  logic [KEY_W-1:0] rdata_q;
  logic [AW-1:0]    raddr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [KEY_W-1:0] mem_wdata;

  sse_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;   // entries issued to memory
  logic [CW-1:0]    cmp_idx_q, cmp_idx_d; // entries compared
  logic [CW-1:0]    kept_q, kept_d;       // delete: survivors written back
  logic             rd_vld_q, rd_vld_d;
  logic             found_q, found_d;
  sse_pkg::cmd_e    cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             res_vld_q, res_vld_d;
  sse_pkg::result_t res_q, res_d;

  logic             accept;
  logic             full;
  logic             empty;
  logic [63:0]      key_wide;
  logic [KEY_W-1:0] key_red;
  logic [63:0]      rdata_wide;
  logic             hit;
  logic [CW-1:0]    cmp_inc;
  logic             scan_last;
  logic             scan_done;
  logic [CW-1:0]    fill_dec;
  logic [CW-1:0]    fill_inc;
  logic [CW-1:0]    srch_addr;
  logic [CW-1:0]    kept_inc;
  logic [31:0]      pos_w;
  logic [31:0]      fill_w;
  logic [31:0]      fill_dec_w;
  logic [31:0]      fill_inc_w;
  logic [31:0]      kept_w;
  logic [31:0]      kept_inc_w;

  assign accept = start && !busy;
  assign busy   = (state_q != sse_pkg::S_IDLE);
  assign full   = (fill_q == CW'(STACK_DEPTH));
  assign empty  = (fill_q == '0);

  // key reduced to KEY_W bits (zero-extended when KEY_W exceeds the field)
  assign key_wide   = 64'(item_i.key);
  assign key_red    = key_wide[KEY_W-1:0];
  assign rdata_wide = 64'(rdata_q);

  assign hit       = (rdata_q == key_q);
  assign cmp_inc   = cmp_idx_q + CW'(1);
  assign scan_last = (cmp_inc == fill_q);
  assign fill_dec  = fill_q - CW'(1);
  assign fill_inc  = fill_q + CW'(1);
  assign kept_inc  = kept_q + CW'(1);
  assign srch_addr = fill_dec - rd_idx_q;

  // search stops at the first hit, delete always walks the whole store
  assign scan_done = rd_vld_q &&
                     ((cmd_q == sse_pkg::CMD_SEARCH) ? (hit || scan_last) : scan_last);

  // counts widened for the 5-bit result fields
  assign pos_w      = 32'(cmp_idx_q) + 32'd1;
  assign fill_w     = 32'(fill_q);
  assign fill_dec_w = 32'(fill_dec);
  assign fill_inc_w = 32'(fill_inc);
  assign kept_w     = 32'(kept_q);
  assign kept_inc_w = 32'(kept_inc);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sse_pkg::S_IDLE: begin
        if (accept) begin
          case (item_i.cmd)
            sse_pkg::CMD_PUSH:   state_d = sse_pkg::S_IDLE;
            sse_pkg::CMD_POP:    state_d = empty ? sse_pkg::S_IDLE : sse_pkg::S_POP;
            sse_pkg::CMD_SEARCH,
            sse_pkg::CMD_DELETE: state_d = empty ? sse_pkg::S_IDLE : sse_pkg::S_SCAN;
            default:             state_d = sse_pkg::S_IDLE;
          endcase
        end
      end
      sse_pkg::S_POP:  state_d = sse_pkg::S_IDLE;
      sse_pkg::S_SCAN: begin
        if (scan_done) state_d = sse_pkg::S_IDLE;
      end
      default: state_d = sse_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fill_d    = fill_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    kept_d    = kept_q;
    rd_vld_d  = 1'b0;
    found_d   = found_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    raddr     = '0;
    mem_we    = 1'b0;
    mem_waddr = fill_q[AW-1:0];
    mem_wdata = key_red;

    case (state_q)
      sse_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d     = item_i.cmd;
          key_d     = key_red;
          rd_idx_d  = '0;
          cmp_idx_d = '0;
          kept_d    = '0;
          found_d   = 1'b0;
          res_d.popped_key = '0;
          res_d.found      = 1'b0;
          res_d.position   = '0;
          res_d.depth_now  = fill_w[4:0];
          res_d.status     = sse_pkg::ST_OK;
          case (item_i.cmd)
            sse_pkg::CMD_PUSH: begin
              res_vld_d = 1'b1;
              if (full) begin
                res_d.status = sse_pkg::ST_FULL;
              end else begin
                mem_we          = 1'b1;
                fill_d          = fill_inc;
                res_d.depth_now = fill_inc_w[4:0];
              end
            end
            sse_pkg::CMD_POP: begin
              raddr = fill_dec[AW-1:0];
              if (empty) begin
                res_vld_d    = 1'b1;
                res_d.status = sse_pkg::ST_EMPTY;
              end
            end
            sse_pkg::CMD_SEARCH,
            sse_pkg::CMD_DELETE: begin
              if (empty) res_vld_d = 1'b1;
            end
            default: ;
          endcase
        end
      end

      sse_pkg::S_POP: begin
        fill_d           = fill_dec;
        res_vld_d        = 1'b1;
        res_d.popped_key = rdata_wide[31:0];
        res_d.depth_now  = fill_dec_w[4:0];
      end

      sse_pkg::S_SCAN: begin
        // issue side: search walks top down, delete bottom up
        if (rd_idx_q != fill_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = rd_idx_q + CW'(1);
        end
        raddr = (cmd_q == sse_pkg::CMD_SEARCH) ? srch_addr[AW-1:0] : rd_idx_q[AW-1:0];

        // compare side, in the cycle after the issue
        if (rd_vld_q) begin
          cmp_idx_d = cmp_inc;
          if (cmd_q == sse_pkg::CMD_SEARCH) begin
            if (scan_done) begin
              res_vld_d       = 1'b1;
              res_d.found     = hit;
              res_d.position  = hit ? pos_w[4:0] : '0;
              res_d.depth_now = fill_w[4:0];
            end
          end else begin
            // survivors move down to the kept slot; it never passes the read pointer
            if (hit) begin
              found_d = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = kept_q[AW-1:0];
              mem_wdata = rdata_q;
              kept_d    = kept_inc;
            end
            if (scan_last) begin
              fill_d          = kept_d;
              res_vld_d       = 1'b1;
              res_d.found     = found_q || hit;
              res_d.position  = '0;
              res_d.depth_now = hit ? kept_w[4:0] : kept_inc_w[4:0];
            end
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sse_pkg::S_IDLE;
      fill_q    <= '0;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rd_vld_q  <= rd_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    kept_q    <= kept_d;
    found_q   <= found_d;
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

@@ tb/sv/tb_searchable_stack_engine.sv @@
// Self-checking bench for searchable_stack_engine: a directed table followed by
// random push/pop/search/delete beats, each scored against an in-bench stack model
// or a result typed into the table. Depends on sse_pkg and searchable_stack_engine.
`timescale 1ns / 1ps

module tb_searchable_stack_engine;

  localparam int unsigned STACK_N     = 16;
  localparam int          RAND_BEATS  = 400;
  localparam int          CALM_FROM   = 320;     // last stretch runs with no idling
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          MAX_REPORTS = 10;
  localparam int          POOL_N      = 6;
  localparam int          DIR_N       = 27;
  localparam int          COUNT_W     = sse_pkg::CountW;

  // traffic mixes for the random part
  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_EVEN   = 2;

  typedef struct {
    bit               fixed;   // result typed into the table, not taken from the model
    sse_pkg::result_t res;
  } pinned_t;

  typedef struct {
    sse_pkg::cmd_e    cmd;
    logic [31:0]      key;
    bit               fixed;
    sse_pkg::result_t res;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  sse_pkg::item_t   item_drv;
  logic             res_valid_o;
  sse_pkg::result_t res_o;

  searchable_stack_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_drv),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Stack model: entries below stack_fill are live, index 0 is the bottom.
  logic [31:0] stack_model [STACK_N];
  int unsigned stack_fill;

  sse_pkg::result_t want_q   [$];   // results still owed by the engine, oldest first
  pinned_t          pinned_q [$];   // per driven beat: typed result, if any
  logic [31:0]      key_pool [POOL_N];
  dir_row_t         dir_rows [DIR_N];

  int err_count;
  int beats_in;
  int results_seen;
  int cycles;
  int full_drops;
  int empty_pops;
  int search_hits;
  int delete_hits;
  int max_depth;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Applies one command to the stack model and returns the result it owes.
  function automatic sse_pkg::result_t stack_apply(sse_pkg::item_t it);
    sse_pkg::result_t r;
    int unsigned      kept;
    r        = '0;
    r.status = sse_pkg::ST_OK;
    case (it.cmd)
      sse_pkg::CMD_PUSH: begin
        if (stack_fill >= STACK_N) begin
          r.status = sse_pkg::ST_FULL;     // key dropped, store unchanged
        end else begin
          stack_model[stack_fill] = it.key;
          stack_fill++;
        end
      end
      sse_pkg::CMD_POP: begin
        if (stack_fill == 0) begin
          r.status = sse_pkg::ST_EMPTY;
        end else begin
          stack_fill--;
          r.popped_key = stack_model[stack_fill];
        end
      end
      sse_pkg::CMD_SEARCH: begin
        // walk from the top; the topmost match wins
        for (int i = 0; i < int'(stack_fill); i++) begin
          if (!r.found && stack_model[int'(stack_fill) - 1 - i] == it.key) begin
            r.found    = 1'b1;
            r.position = COUNT_W'(i + 1);
          end
        end
      end
      default: begin
        // delete every match, compact the rest in order
        kept = 0;
        for (int i = 0; i < int'(stack_fill); i++) begin
          if (stack_model[i] == it.key) begin
            r.found = 1'b1;
          end else begin
            stack_model[kept] = stack_model[i];
            kept++;
          end
        end
        stack_fill = kept;
      end
    endcase
    r.depth_now = COUNT_W'(stack_fill);
    return r;
  endfunction

  function automatic dir_row_t dir_row(sse_pkg::cmd_e c, logic [31:0] k, bit fx,
                                       logic [31:0] pk, logic fnd, logic [4:0] pos,
                                       logic [4:0] dep, sse_pkg::status_e st);
    dir_row_t row;
    row.cmd              = c;
    row.key              = k;
    row.fixed            = fx;
    row.res.popped_key   = pk;
    row.res.found        = fnd;
    row.res.position     = pos;
    row.res.depth_now    = dep;
    row.res.status       = st;
    return row;
  endfunction

  // Random beat. Keys mostly come from a small pool or from the live stack so
  // that searches hit and deletes remove several copies; the rest are raw.
  function automatic sse_pkg::item_t pick_item(int mix);
    sse_pkg::item_t it;
    int             roll;
    roll = $urandom_range(99, 0);
    case (mix)
      MIX_GROW:
        it.cmd = roll < 65 ? sse_pkg::CMD_PUSH : roll < 75 ? sse_pkg::CMD_POP :
                 roll < 90 ? sse_pkg::CMD_SEARCH : sse_pkg::CMD_DELETE;
      MIX_SHRINK:
        it.cmd = roll < 20 ? sse_pkg::CMD_PUSH : roll < 55 ? sse_pkg::CMD_POP :
                 roll < 75 ? sse_pkg::CMD_SEARCH : sse_pkg::CMD_DELETE;
      default:
        it.cmd = roll < 25 ? sse_pkg::CMD_PUSH : roll < 50 ? sse_pkg::CMD_POP :
                 roll < 75 ? sse_pkg::CMD_SEARCH : sse_pkg::CMD_DELETE;
    endcase
    roll = $urandom_range(9, 0);
    if (roll < 4) begin
      it.key = key_pool[$urandom_range(POOL_N - 1, 0)];
    end else if (roll < 7 && stack_fill != 0) begin
      it.key = stack_model[$urandom_range(stack_fill - 1, 0)];
    end else begin
      it.key = $urandom;
    end
    return it;
  endfunction

  task automatic flag(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      flag($sformatf("result %0d %s: expected %h, got %h", results_seen, name, want, got));
  endtask

  // Called at a falling edge. Holds the beat until the engine takes it, then
  // returns at the next falling edge; start stays high so back-to-back beats
  // need no second assignment in one step.
  task automatic send(sse_pkg::item_t it, bit fixed, sse_pkg::result_t res);
    pinned_q.push_back('{fixed, res});
    item_drv <= it;
    start    <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Sender holds off until every owed result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (want_q.size() != 0);
  endtask

  // Scoreboard. Results are scored before the same-edge accept is logged: a
  // beat accepted at this edge can never have its result here already.
  always @(posedge clk_i) begin
    sse_pkg::result_t got;
    sse_pkg::result_t want;
    sse_pkg::result_t pred;
    pinned_t          pin;
    if (rst_ni) begin
      if (res_valid_o) begin
        got = res_o;
        results_seen++;
        if (want_q.size() == 0) begin
          flag($sformatf("result %0d arrived with nothing outstanding", results_seen));
        end else begin
          want = want_q.pop_front();
          check_field("popped_key", want.popped_key, got.popped_key);
          check_field("found",      32'(want.found),     32'(got.found));
          check_field("position",   32'(want.position),  32'(got.position));
          check_field("depth_now",  32'(want.depth_now), 32'(got.depth_now));
          check_field("status",     32'(want.status),    32'(got.status));
        end
      end
      if (start && !busy) begin
        beats_in++;
        pred = stack_apply(item_drv);
        pin  = pinned_q.pop_front();
        want_q.push_back(pin.fixed ? pin.res : pred);
        if (pred.status == sse_pkg::ST_FULL) full_drops++;
        if (pred.status == sse_pkg::ST_EMPTY) empty_pops++;
        if (item_drv.cmd == sse_pkg::CMD_SEARCH && pred.found) search_hits++;
        if (item_drv.cmd == sse_pkg::CMD_DELETE && pred.found) delete_hits++;
        if (int'(stack_fill) > max_depth) max_depth = int'(stack_fill);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycles, want_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int mix;

    rst_ni     = 1'b0;
    start      = 1'b0;
    item_drv   = '0;
    stack_fill = 0;
    err_count  = 0;
    beats_in   = 0;
    results_seen = 0;
    cycles     = 0;
    full_drops = 0;
    empty_pops = 0;
    search_hits = 0;
    delete_hits = 0;
    max_depth  = 0;
    mix        = MIX_EVEN;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;

    // Directed table. Typed results only where they are plain: empty store, first
    // pushes, last entry deleted, fill to full, push on full, bottom-of-stack search.
    dir_rows = '{
      dir_row(sse_pkg::CMD_POP,    32'h0000_0000, 1, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_EMPTY),
      dir_row(sse_pkg::CMD_SEARCH, 32'h0000_0000, 1, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_DELETE, 32'hFFFF_FFFF, 1, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h0000_0000, 1, 32'h0, 1'b0, 5'd0, 5'd1, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_DELETE, 32'h0000_0000, 1, 32'h0, 1'b1, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'hFFFF_FFFF, 1, 32'h0, 1'b0, 5'd0, 5'd1, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h0000_0000, 1, 32'h0, 1'b0, 5'd0, 5'd2, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'hAAAA_AAAA, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h5555_5555, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h0000_5A5A, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h8000_0001, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h0000_5A5A, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h7FFF_FFFE, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h1234_5678, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h0000_5A5A, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'hFEDC_BA98, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h0000_0001, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h8000_0000, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h0000_5A5A, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'hC3C3_3C3C, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'h0F0F_F0F0, 1, 32'h0, 1'b0, 5'd0, 5'd16, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_PUSH,   32'hDEAD_BEEF, 1, 32'h0, 1'b0, 5'd0, 5'd16, sse_pkg::ST_FULL),
      dir_row(sse_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 1, 32'h0, 1'b1, 5'd16, 5'd16, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_SEARCH, 32'h0000_5A5A, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_DELETE, 32'h0000_5A5A, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_POP,    32'hFFFF_FFFF, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK),
      dir_row(sse_pkg::CMD_SEARCH, 32'h1111_1111, 0, 32'h0, 1'b0, 5'd0, 5'd0, sse_pkg::ST_OK)
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      sse_pkg::item_t it;
      it.cmd = dir_rows[i].cmd;
      it.key = dir_rows[i].key;
      if ($urandom_range(3, 0) == 0) idle($urandom_range(13, 1));
      send(it, dir_rows[i].fixed, dir_rows[i].res);
    end
    drain();

    // Random part: the mix shifts every 30 beats so the stack swings between
    // empty and full. One quiet window and the tail run with no gaps at all,
    // and halfway through the sender waits for the engine to drain.
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n % 30 == 0) mix = $urandom_range(MIX_EVEN, MIX_GROW);
      if (n == RAND_BEATS / 2) begin
        drain();
      end else if (n < CALM_FROM && !(n >= 100 && n < 160) &&
                   $urandom_range(4, 0) == 0) begin
        idle($urandom_range(13, 1));
      end
      send(pick_item(mix), 1'b0, '0);
    end

    drain();
    // longest walk is a full-stack search or delete; give it slack
    repeat (2 * STACK_N + 8) @(posedge clk_i);

    $display("ran %0d beats, %0d results; push on full %0d, pop on empty %0d",
             beats_in, results_seen, full_drops, empty_pops);
    $display("search hits %0d, deletes that removed keys %0d, deepest fill %0d, errors %0d",
             search_hits, delete_hits, max_depth, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
